FILE: sv/fps_pkg.sv
// Shared constants, types and codes for the Fenwick prefix search block.
package fps_pkg;

    // Table geometry
    localparam int TABLE_SIZE = 1024;

    // Greatest power of two not above the table size
    function automatic int top_mask_f();
        int m;
        m = 1;
        while (m <= TABLE_SIZE / 2)
        begin
            m = m * 2;
        end
        return m;
    endfunction

    localparam int TOP_MASK = top_mask_f();
    localparam int IDX_W    = $clog2(TABLE_SIZE + 1);
    localparam int NODE_W   = IDX_W + 1;
    localparam int ADDR_W   = $clog2(TABLE_SIZE);

    // Fixed field widths
    localparam int CMD_W   = 2;
    localparam int ENTRY_W = 11;
    localparam int WORD_W  = 31;
    localparam int STAT_W  = 2;
    localparam int POS_W   = 11;
    localparam int CMP_W   = (IDX_W > ENTRY_W) ? IDX_W : ENTRY_W;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_WRITE    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ANY      = 2'd1;
    localparam logic [CMD_W-1:0] CMD_GREATEST = 2'd2;

    // Status codes
    localparam logic [STAT_W-1:0] ST_WRITE = 2'd0;
    localparam logic [STAT_W-1:0] ST_FOUND = 2'd1;
    localparam logic [STAT_W-1:0] ST_MISS  = 2'd2;

    typedef logic [WORD_W-1:0] word_t;
    typedef logic [IDX_W-1:0]  idx_t;
    typedef logic [NODE_W-1:0] node_t;
    typedef logic [ADDR_W-1:0] addr_t;

    // Controller to datapath commands
    typedef struct packed {
        logic  clr_we;
        addr_t clr_addr;
        logic  load;
        logic  start;
        logic  step;
        logic  load_out;
    } ctl_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic is_search;
        logic step_done;
    } dp_stat_t;

endpackage

FILE: sv/fps_req_if.sv
// Request channel: command, entry index and amount with valid/ready.
interface fps_req_if;
    logic                         valid;
    logic                         ready;
    logic [fps_pkg::CMD_W-1:0]    command;
    logic [fps_pkg::ENTRY_W-1:0]  entry_index;
    logic [fps_pkg::WORD_W-1:0]   amount;

    modport source (output valid, command, entry_index, amount, input ready);
    modport sink   (input valid, command, entry_index, amount, output ready);
endinterface

FILE: sv/fps_rsp_if.sv
// Response channel: status and position with valid/ready.
interface fps_rsp_if;
    logic                        valid;
    logic                        ready;
    logic [fps_pkg::STAT_W-1:0]  status;
    logic [fps_pkg::POS_W-1:0]   position;

    modport source (output valid, status, position, input ready);
    modport sink   (input valid, status, position, output ready);
endinterface

FILE: sv/fps_datapath.sv
// Datapath: tree memory, descent registers, result and output registers.
module fps_datapath (
    input  logic                        clk,
    input  fps_pkg::ctl_cmd_t           ctl,
    output fps_pkg::dp_stat_t           stat,
    input  logic [fps_pkg::CMD_W-1:0]   req_command,
    input  logic [fps_pkg::ENTRY_W-1:0] req_entry_index,
    input  fps_pkg::word_t              req_amount,
    output logic [fps_pkg::STAT_W-1:0]  rsp_status,
    output logic [fps_pkg::POS_W-1:0]   rsp_position
);

    // Tree memory, one write port and two registered read ports
    fps_pkg::word_t tree_mem [fps_pkg::TABLE_SIZE];

    // Captured request
    logic [fps_pkg::CMD_W-1:0]   cmd_reg;
    logic [fps_pkg::ENTRY_W-1:0] entry_reg;
    fps_pkg::word_t              amount_reg;

    // Descent state
    fps_pkg::idx_t  idx_reg;
    fps_pkg::word_t rem_reg;
    fps_pkg::idx_t  mask_reg;
    logic           sel_reg;
    logic           vld_a_reg;
    logic           vld_b_reg;
    logic           greatest_reg;
    fps_pkg::word_t rd_a_reg;
    fps_pkg::word_t rd_b_reg;

    // Result and output payload
    logic [fps_pkg::STAT_W-1:0] res_status_reg;
    logic [fps_pkg::POS_W-1:0]  res_pos_reg;
    logic [fps_pkg::STAT_W-1:0] rsp_status_reg;
    logic [fps_pkg::POS_W-1:0]  rsp_pos_reg;

    // Level evaluation
    fps_pkg::word_t w;
    logic           node_ok;
    fps_pkg::node_t node;
    logic           hit;
    logic           take;
    fps_pkg::idx_t  idx_step;
    fps_pkg::word_t rem_step;
    fps_pkg::idx_t  half;
    fps_pkg::node_t cand_a;
    fps_pkg::node_t cand_b;
    logic           last;

    // Memory port controls
    fps_pkg::addr_t            rd_addr_a;
    fps_pkg::addr_t            rd_addr_b;
    logic                      we;
    fps_pkg::addr_t            wr_addr;
    fps_pkg::word_t            wr_data;
    logic [fps_pkg::CMP_W-1:0] entry_ext;
    logic                      entry_ok;

    // Evaluate the current level of the descent
    always_comb
    begin
        w        = sel_reg ? rd_b_reg : rd_a_reg;
        node_ok  = sel_reg ? vld_b_reg : vld_a_reg;
        node     = fps_pkg::NODE_W'(idx_reg) + fps_pkg::NODE_W'(mask_reg);
        hit      = node_ok && !greatest_reg && (rem_reg == w);
        take     = node_ok && (greatest_reg ? (rem_reg >= w) : (rem_reg > w));
        idx_step = take ? fps_pkg::IDX_W'(node) : idx_reg;
        rem_step = take ? (rem_reg - w) : rem_reg;
        half     = mask_reg >> 1;
        cand_a   = fps_pkg::NODE_W'(idx_reg) + fps_pkg::NODE_W'(half);
        cand_b   = node + fps_pkg::NODE_W'(half);
        last     = (mask_reg == fps_pkg::IDX_W'(1));
    end

    assign stat.is_search = (cmd_reg == fps_pkg::CMD_ANY) || (cmd_reg == fps_pkg::CMD_GREATEST);
    assign stat.step_done = hit || last;

    // Select read addresses: top node at start, both children while walking
    always_comb
    begin
        if (ctl.start)
        begin
            rd_addr_a = fps_pkg::ADDR_W'(fps_pkg::TOP_MASK - 1);
            rd_addr_b = fps_pkg::ADDR_W'(fps_pkg::TOP_MASK - 1);
        end
        else
        begin
            rd_addr_a = fps_pkg::ADDR_W'(cand_a - fps_pkg::NODE_W'(1));
            rd_addr_b = fps_pkg::ADDR_W'(cand_b - fps_pkg::NODE_W'(1));
        end
    end

    // Select the write: clearing sweep or a tree word load
    always_comb
    begin
        entry_ext = fps_pkg::CMP_W'(entry_reg);
        entry_ok  = (entry_ext != '0) && (entry_ext <= fps_pkg::CMP_W'(fps_pkg::TABLE_SIZE));
        if (ctl.clr_we)
        begin
            we      = 1'b1;
            wr_addr = ctl.clr_addr;
            wr_data = '0;
        end
        else
        begin
            we      = ctl.start && (cmd_reg == fps_pkg::CMD_WRITE) && entry_ok;
            wr_addr = fps_pkg::ADDR_W'(entry_ext - fps_pkg::CMP_W'(1));
            wr_data = amount_reg;
        end
    end

    // Memory access
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            tree_mem[wr_addr] <= wr_data;
        end
        rd_a_reg <= tree_mem[rd_addr_a];
        rd_b_reg <= tree_mem[rd_addr_b];
    end

    // Capture, start, advance and finish
    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            cmd_reg    <= req_command;
            entry_reg  <= req_entry_index;
            amount_reg <= req_amount;
        end
        if (ctl.start)
        begin
            idx_reg        <= '0;
            rem_reg        <= amount_reg;
            mask_reg       <= fps_pkg::IDX_W'(fps_pkg::TOP_MASK);
            sel_reg        <= 1'b0;
            vld_a_reg      <= 1'b1;
            vld_b_reg      <= 1'b0;
            greatest_reg   <= (cmd_reg == fps_pkg::CMD_GREATEST);
            res_status_reg <= (cmd_reg == fps_pkg::CMD_WRITE) ? fps_pkg::ST_WRITE
                                                              : fps_pkg::ST_MISS;
            res_pos_reg    <= '0;
        end
        else if (ctl.step)
        begin
            idx_reg   <= idx_step;
            rem_reg   <= rem_step;
            mask_reg  <= half;
            sel_reg   <= take;
            vld_a_reg <= (cand_a <= fps_pkg::NODE_W'(fps_pkg::TABLE_SIZE));
            vld_b_reg <= (cand_b <= fps_pkg::NODE_W'(fps_pkg::TABLE_SIZE));
            if (hit)
            begin
                res_status_reg <= fps_pkg::ST_FOUND;
                res_pos_reg    <= fps_pkg::POS_W'(node);
            end
            else if (last)
            begin
                if (rem_step == '0)
                begin
                    res_status_reg <= fps_pkg::ST_FOUND;
                    res_pos_reg    <= fps_pkg::POS_W'(idx_step);
                end
                else
                begin
                    res_status_reg <= fps_pkg::ST_MISS;
                    res_pos_reg    <= '0;
                end
            end
        end
        if (ctl.load_out)
        begin
            rsp_status_reg <= res_status_reg;
            rsp_pos_reg    <= res_pos_reg;
        end
    end

    assign rsp_status   = rsp_status_reg;
    assign rsp_position = rsp_pos_reg;

endmodule

FILE: sv/fps_controller.sv
// Controller: clearing sweep, command sequencing and response handshake.
module fps_controller (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_ready,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    output fps_pkg::ctl_cmd_t   ctl,
    input  fps_pkg::dp_stat_t   stat
);

    localparam logic [2:0] S_CLEAR  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_START  = 3'd2;
    localparam logic [2:0] S_WALK   = 3'd3;
    localparam logic [2:0] S_FINISH = 3'd4;

    logic [2:0]     state_reg;
    logic [2:0]     state_next;
    fps_pkg::addr_t clr_cnt_reg;
    fps_pkg::addr_t clr_cnt_next;
    logic           out_valid_reg;
    logic           out_valid_next;
    logic           out_free;

    assign out_free = !out_valid_reg || rsp_ready;

    // Next state and commands
    always_comb
    begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        ctl            = '0;
        ctl.clr_addr   = clr_cnt_reg;
        req_ready      = 1'b0;
        out_valid_next = out_valid_reg && !rsp_ready;
        case (state_reg)
            S_CLEAR:
            begin
                ctl.clr_we   = 1'b1;
                clr_cnt_next = clr_cnt_reg + fps_pkg::ADDR_W'(1);
                if (clr_cnt_reg == fps_pkg::ADDR_W'(fps_pkg::TABLE_SIZE - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    ctl.load   = 1'b1;
                    state_next = S_START;
                end
            end
            S_START:
            begin
                ctl.start  = 1'b1;
                state_next = stat.is_search ? S_WALK : S_FINISH;
            end
            S_WALK:
            begin
                ctl.step = 1'b1;
                if (stat.step_done)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    ctl.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign rsp_valid = out_valid_reg;

endmodule

FILE: sv/fenwick_prefix_search_top.sv
// Flow: a transferred request is captured, started, walked level by level (searches only),
// then moved to the response register; a search visits L = log2 of the top mask + 1 levels
// (11 levels at 1024 entries), fewer on an early exact match. One request is in flight.
// One dual-read tree memory access per level sets the walk rate: both children are read at once.
// After reset the tree memory is swept to zero over all TABLE_SIZE entries (1024) with ready low.
// rst_n is asynchronous, active low, and clears the controller and the response valid.
module fenwick_prefix_search_top (
    input logic         clk,
    input logic         rst_n,
    fps_req_if.sink     req,
    fps_rsp_if.source   rsp
);

    fps_pkg::ctl_cmd_t ctl;
    fps_pkg::dp_stat_t stat;

    fps_controller u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .ctl       (ctl),
        .stat      (stat)
    );

    fps_datapath u_dp (
        .clk             (clk),
        .ctl             (ctl),
        .stat            (stat),
        .req_command     (req.command),
        .req_entry_index (req.entry_index),
        .req_amount      (req.amount),
        .rsp_status      (rsp.status),
        .rsp_position    (rsp.position)
    );

endmodule

FILE: sv/fps_checker.sv
// Port-level checks for the Fenwick prefix search top level, with its bind.
module fps_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        req_valid,
    input logic                        req_ready,
    input logic                        rsp_valid,
    input logic                        rsp_ready,
    input logic [fps_pkg::STAT_W-1:0]  rsp_status,
    input logic [fps_pkg::POS_W-1:0]   rsp_position
);

    // Hold a stalled response
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) && $stable(rsp_position))
        else $error("response changed while stalled");

    // Drive position only for a found index
    a_pos_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_status != fps_pkg::ST_FOUND) |-> (rsp_position == '0))
        else $error("nonzero position without a find");

    // Drop ready after each request transfer
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("second request taken while one is in flight");

    // Raise response valid only out of a busy cycle
    a_rsp_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> !$past(req_ready))
        else $error("response appeared straight out of idle");

endmodule

bind fenwick_prefix_search_top fps_checker u_fps_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .req_valid    (req.valid),
    .req_ready    (req.ready),
    .rsp_valid    (rsp.valid),
    .rsp_ready    (rsp.ready),
    .rsp_status   (rsp.status),
    .rsp_position (rsp.position)
);
